// ----- design/rag_pkg.sv -----
// ---------------------------------------------------------------------------
// rag_pkg
// Shared types, codes and helpers of the ring allgather control engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rag_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] msg_seq;
        logic [7:0]  origin_id;
        logic [5:0]  hop_number;
        logic        size_matches;
        logic [1:0]  context_index;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reason;
        logic [1:0]  ctx_slot;
        logic [31:0] out_seq;
        logic [5:0]  fwd_origin;
        logic [5:0]  fwd_hop;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOCAL = 2'd0,
        OP_MSG   = 2'd1,
        OP_SENT  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } q_item_t;

    localparam logic [1:0] MODE_LOCAL = 2'd0;
    localparam logic [1:0] MODE_MSG   = 2'd1;
    localparam logic [1:0] MODE_SENT  = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    localparam logic [2:0] KIND_REJECT   = 3'd0;
    localparam logic [2:0] KIND_FORWARD  = 3'd1;
    localparam logic [2:0] KIND_DELIVER  = 3'd2;
    localparam logic [2:0] KIND_COMPLETE = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_NOCTX = 3'd1;
    localparam logic [2:0] RSN_SIZE  = 3'd2;
    localparam logic [2:0] RSN_HOP   = 3'd3;
    localparam logic [2:0] RSN_RANGE = 3'd4;
    localparam logic [2:0] RSN_DUP   = 3'd5;

    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_PROG = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    localparam logic [1:0] CFG_PEER_COUNT = 2'd0;
    localparam logic [1:0] CFG_OWN_ID     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    function automatic out_item_t mk_res(input logic [2:0] kind, input logic [2:0] reason,
                                         input logic [1:0] slot, input logic [31:0] seq,
                                         input logic [5:0] origin, input logic [5:0] hop);
        out_item_t r;
        r.kind       = kind;
        r.reason     = reason;
        r.ctx_slot   = slot;
        r.out_seq    = seq;
        r.fwd_origin = origin;
        r.fwd_hop    = hop;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/rag_front.sv -----
// ---------------------------------------------------------------------------
// rag_front
// Accepts event items, decodes the event class and queues them for the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rag_front
    import rag_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          q_valid,
    output q_item_t       q_data,
    input  wire logic     q_pop
);

    q_item_t    fifo_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    op_t        op_dec;

    always_comb begin
        unique case (s_data.mode)
            MODE_LOCAL: op_dec = OP_LOCAL;
            MODE_MSG:   op_dec = OP_MSG;
            MODE_SENT:  op_dec = OP_SENT;
            MODE_TICK:  op_dec = OP_TICK;
            default:    op_dec = OP_TICK;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= '{op: op_dec, item: s_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

`default_nettype wire

// ----- design/rag_div.sv -----
// ---------------------------------------------------------------------------
// rag_div
// Bit-serial restoring remainder unit: 32-bit dividend by a 7-bit divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rag_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [6:0]  divisor,
    output logic             done,
    output logic [6:0]       rem
);

    logic [31:0] dvd_reg;
    logic [6:0]  dsr_reg;
    logic [6:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [7:0]  trial;
    logic [7:0]  rem_next;

    assign trial    = {rem_reg, dvd_reg[31]};
    assign rem_next = (trial >= {1'b0, dsr_reg}) ? trial - {1'b0, dsr_reg} : trial;
    assign done     = done_reg;
    assign rem      = rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= 7'd0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/rag_engine.sv -----
// ---------------------------------------------------------------------------
// rag_engine
// Back end: context table, sequencer for events and phase advance, results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rag_engine
    import rag_pkg::*;
#(
    parameter int CONTEXTS  = 3,
    parameter int MAX_PEERS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        q_valid,
    input  wire q_item_t     q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    localparam int SLOT_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int PIDX_W = $clog2(MAX_PEERS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CALC  = 8'b0000_0010,
        ST_EXEC  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_ADV   = 8'b0010_0000,
        ST_TICK  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } state_t;

    // configuration
    logic [6:0]  peer_count_reg;
    logic [5:0]  own_id_reg;
    logic [31:0] limit_reg;
    logic [5:0]  own_eff_reg;
    logic        recalc_reg;

    // context table
    logic [CONTEXTS-1:0]  in_use_reg, in_use_next;
    logic [1:0]           phase_reg [CONTEXTS];
    logic [1:0]           phase_next [CONTEXTS];
    logic [CONTEXTS-1:0]  local_reg, local_next;
    logic [6:0]           prev_reg [CONTEXTS];
    logic [6:0]           prev_next [CONTEXTS];
    logic [6:0]           fwd_reg [CONTEXTS];
    logic [6:0]           fwd_next [CONTEXTS];
    logic [31:0]          seq_reg [CONTEXTS];
    logic [31:0]          seq_next [CONTEXTS];
    logic [MAX_PEERS-1:0] seen_reg [CONTEXTS];
    logic [MAX_PEERS-1:0] seen_next [CONTEXTS];
    logic [31:0]          coll_seq_reg, coll_seq_next;
    logic [31:0]          las_reg, las_next;
    logic                 armed_reg, armed_next;

    // sequencer
    state_t            state_reg, state_next;
    q_item_t           cur_reg, cur_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] tick_reg, tick_next;
    logic [6:0]        chk_rem_reg, chk_rem_next;
    logic              recalc_clr;
    logic              item_start;

    // results
    logic [2:0] emit_cnt_reg;
    logic       pend_valid_reg;
    out_item_t  pend_reg;
    out_item_t  pend_last;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       res_want;
    out_item_t  res_data;
    logic       emit_ok;
    logic       out_free;
    logic       go;
    logic       push_pend;
    logic       flush_push;

    // divider
    logic        div_start;
    logic [31:0] div_dvd;
    logic [6:0]  div_dsr;
    logic        div_done;
    logic [6:0]  div_rem;

    // scans
    logic [6:0]        p_eff;
    logic [6:0]        own_p1;
    logic [5:0]        next_peer;
    logic              loc_found, msg_found, spare_ok;
    logic [SLOT_W-1:0] loc_idx, msg_idx, spare_idx;
    logic [3:0]        fin_cnt;
    logic [31:0]       new_seq;
    logic [SLOT_W-1:0] s;
    logic              sent_ok;
    logic [6:0]        have;
    in_item_t          it;

    rag_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        if (peer_count_reg == 7'd0) p_eff = 7'd1;
        else if (peer_count_reg > 7'(MAX_PEERS)) p_eff = 7'(MAX_PEERS);
        else p_eff = peer_count_reg;
    end

    assign own_p1    = {1'b0, own_eff_reg} + 7'd1;
    assign next_peer = (own_p1 == p_eff) ? 6'd0 : own_p1[5:0];
    assign it        = cur_reg.item;

    always_comb begin
        loc_found = 1'b0;
        loc_idx   = '0;
        msg_found = 1'b0;
        msg_idx   = '0;
        spare_ok  = 1'b0;
        spare_idx = '0;
        fin_cnt   = 4'd0;
        for (int i = 0; i < CONTEXTS; i++) begin
            if (in_use_reg[i]) begin
                if (phase_reg[i] == PH_FIN) begin
                    fin_cnt = fin_cnt + 4'd1;
                end else if (!loc_found && !local_reg[i]) begin
                    loc_found = 1'b1;
                    loc_idx   = SLOT_W'(i);
                end
                if (!msg_found && seq_reg[i] == it.msg_seq) begin
                    msg_found = 1'b1;
                    msg_idx   = SLOT_W'(i);
                end
            end else begin
                spare_ok  = 1'b1;
                spare_idx = SLOT_W'(i);
            end
        end
    end

    assign new_seq = coll_seq_reg + 32'(fin_cnt);
    assign sent_ok = (32'(it.context_index) < CONTEXTS);
    assign s       = slot_reg;
    assign have    = prev_reg[s] + {6'd0, local_reg[s]};

    // one step of the sequencer; taken only when go is high
    always_comb begin
        in_use_next   = in_use_reg;
        phase_next    = phase_reg;
        local_next    = local_reg;
        prev_next     = prev_reg;
        fwd_next      = fwd_reg;
        seq_next      = seq_reg;
        seen_next     = seen_reg;
        coll_seq_next = coll_seq_reg;
        las_next      = las_reg;
        armed_next    = armed_reg;
        state_next    = state_reg;
        cur_next      = cur_reg;
        slot_next     = slot_reg;
        tick_next     = tick_reg;
        chk_rem_next  = chk_rem_reg;
        recalc_clr    = 1'b0;
        item_start    = 1'b0;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        div_dvd       = {26'd0, own_id_reg};
        div_dsr       = p_eff;
        res_want      = 1'b0;
        res_data      = mk_res(KIND_REJECT, RSN_NONE, 2'd0, 32'd0, 6'd0, 6'd0);

        unique case (state_reg)
            ST_IDLE: begin
                if (recalc_reg) begin
                    div_start  = 1'b1;
                    recalc_clr = 1'b1;
                    state_next = ST_CALC;
                end else if (q_valid) begin
                    q_pop      = 1'b1;
                    item_start = 1'b1;
                    cur_next   = q_data;
                    tick_next  = '0;
                    state_next = (q_data.op == OP_TICK) ? ST_TICK : ST_EXEC;
                end
            end
            ST_CALC: begin
                if (div_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC: begin
                unique case (cur_reg.op)
                    OP_LOCAL: begin
                        armed_next = 1'b1;
                        if (!loc_found && !spare_ok) begin
                            res_want   = 1'b1;
                            res_data   = mk_res(KIND_REJECT, RSN_NOCTX, 2'd0, coll_seq_reg,
                                                6'd0, 6'd0);
                            state_next = ST_FLUSH;
                        end else begin
                            if (loc_found) begin
                                slot_next = loc_idx;
                                if (own_eff_reg != next_peer) begin
                                    res_want = 1'b1;
                                    res_data = mk_res(KIND_FORWARD, RSN_NONE, 2'(loc_idx),
                                                      seq_reg[loc_idx], own_eff_reg, 6'd0);
                                end
                                local_next[loc_idx] = 1'b1;
                            end else begin
                                slot_next            = spare_idx;
                                in_use_next[spare_idx] = 1'b1;
                                seq_next[spare_idx]    = new_seq;
                                if (own_eff_reg != next_peer) begin
                                    res_want = 1'b1;
                                    res_data = mk_res(KIND_FORWARD, RSN_NONE, 2'(spare_idx),
                                                      new_seq, own_eff_reg, 6'd0);
                                end
                                local_next[spare_idx] = 1'b1;
                            end
                            las_next   = it.now_time;
                            state_next = ST_ADV;
                        end
                    end
                    OP_MSG: begin
                        if (!msg_found && !spare_ok) begin
                            res_want   = 1'b1;
                            res_data   = mk_res(KIND_REJECT, RSN_NOCTX, 2'd0, it.msg_seq,
                                                6'd0, 6'd0);
                            state_next = ST_FLUSH;
                        end else begin
                            slot_next = msg_found ? msg_idx : spare_idx;
                            if (!msg_found) begin
                                in_use_next[spare_idx] = 1'b1;
                                seq_next[spare_idx]    = it.msg_seq;
                            end
                            if (!it.size_matches) begin
                                res_want   = 1'b1;
                                res_data   = mk_res(KIND_REJECT, RSN_SIZE,
                                                    2'(msg_found ? msg_idx : spare_idx),
                                                    it.msg_seq, 6'd0, 6'd0);
                                state_next = ST_FLUSH;
                            end else begin
                                // (own + P - origin) wraps at 32 bits
                                div_start  = 1'b1;
                                div_dvd    = {26'd0, own_eff_reg} + {25'd0, p_eff}
                                             - {24'd0, it.origin_id};
                                state_next = ST_DIV;
                            end
                        end
                    end
                    OP_SENT: begin
                        if (sent_ok && in_use_reg[SLOT_W'(it.context_index)]
                            && seq_reg[SLOT_W'(it.context_index)] == it.msg_seq) begin
                            slot_next = SLOT_W'(it.context_index);
                            fwd_next[SLOT_W'(it.context_index)] =
                                fwd_reg[SLOT_W'(it.context_index)] + 7'd1;
                            state_next = ST_ADV;
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end
                    default: begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    chk_rem_next = div_rem;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // expected hop is remainder minus one; a zero remainder never matches
                if (chk_rem_reg == 7'd0 || (chk_rem_reg - 7'd1) != {1'b0, it.hop_number}) begin
                    res_want   = 1'b1;
                    res_data   = mk_res(KIND_REJECT, RSN_HOP, 2'(s), seq_reg[s], 6'd0, 6'd0);
                    state_next = ST_FLUSH;
                end else if (it.origin_id >= {1'b0, p_eff}) begin
                    res_want   = 1'b1;
                    res_data   = mk_res(KIND_REJECT, RSN_RANGE, 2'(s), seq_reg[s], 6'd0, 6'd0);
                    state_next = ST_FLUSH;
                end else if (seen_reg[s][it.origin_id[PIDX_W-1:0]]) begin
                    res_want   = 1'b1;
                    res_data   = mk_res(KIND_REJECT, RSN_DUP, 2'(s), seq_reg[s], 6'd0, 6'd0);
                    state_next = ST_FLUSH;
                end else begin
                    seen_next[s][it.origin_id[PIDX_W-1:0]] = 1'b1;
                    las_next     = it.now_time;
                    prev_next[s] = prev_reg[s] + 7'd1;
                    if (it.origin_id[5:0] != next_peer) begin
                        res_want = 1'b1;
                        res_data = mk_res(KIND_FORWARD, RSN_NONE, 2'(s), seq_reg[s],
                                          it.origin_id[5:0], it.hop_number + 6'd1);
                    end
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                state_next = ST_FLUSH;
                case (phase_reg[s])
                    PH_SYNC: begin
                        if (local_reg[s] || prev_reg[s] != 7'd0) begin
                            phase_next[s] = PH_PROG;
                            state_next    = ST_ADV;
                        end
                    end
                    PH_PROG: begin
                        if (have == p_eff) begin
                            phase_next[s] = PH_FIN;
                            if (armed_reg) begin
                                res_want   = 1'b1;
                                res_data   = mk_res(KIND_DELIVER, RSN_NONE, 2'(s), seq_reg[s],
                                                    6'd0, 6'd0);
                                armed_next = 1'b0;
                            end
                            state_next = ST_ADV;
                        end
                    end
                    PH_FIN: begin
                        if (fwd_reg[s] + 7'd1 == p_eff) begin
                            coll_seq_next  = coll_seq_reg + 32'd1;
                            res_want       = 1'b1;
                            res_data       = mk_res(KIND_COMPLETE, RSN_NONE, 2'(s), seq_reg[s],
                                                    6'd0, 6'd0);
                            in_use_next[s] = 1'b0;
                            phase_next[s]  = PH_SYNC;
                            local_next[s]  = 1'b0;
                            prev_next[s]   = 7'd0;
                            fwd_next[s]    = 7'd0;
                            seen_next[s]   = '0;
                            las_next       = it.now_time;
                            state_next     = ST_ADV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_TICK: begin
                if (in_use_reg[tick_reg] && phase_reg[tick_reg] != PH_SYNC
                    && (it.now_time - las_reg) > limit_reg) begin
                    armed_next            = 1'b0;
                    res_want              = 1'b1;
                    res_data              = mk_res(KIND_TIMEOUT, RSN_NONE, 2'(tick_reg),
                                                   seq_reg[tick_reg], 6'd0, 6'd0);
                    in_use_next[tick_reg] = 1'b0;
                    phase_next[tick_reg]  = PH_SYNC;
                    local_next[tick_reg]  = 1'b0;
                    prev_next[tick_reg]   = 7'd0;
                    fwd_next[tick_reg]    = 7'd0;
                    seen_next[tick_reg]   = '0;
                    las_next              = it.now_time;
                end
                if (tick_reg == SLOT_W'(CONTEXTS - 1)) state_next = ST_FLUSH;
                else tick_next = tick_reg + SLOT_W'(1);
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // at most four results per item; the newest one is held back to mark last
    assign emit_ok    = res_want && (emit_cnt_reg < 3'd4);
    assign out_free   = !m_valid_reg || m_ready;
    assign go         = !(emit_ok && pend_valid_reg && !out_free);
    assign push_pend  = go && emit_ok && pend_valid_reg;
    assign flush_push = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    always_comb begin
        pend_last      = pend_reg;
        pend_last.last = 1'b1;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (go) begin
            cur_reg     <= cur_next;
            chk_rem_reg <= chk_rem_next;
        end
        if (go && emit_ok) pend_reg <= res_data;
        if (push_pend) begin
            m_data_reg <= pend_reg;
        end else if (flush_push) begin
            m_data_reg <= pend_last;
        end
        if (!aresetn) own_eff_reg <= 6'd0;
        else if (div_done && state_reg == ST_CALC) own_eff_reg <= div_rem[5:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peer_count_reg <= 7'd1;
            own_id_reg     <= 6'd0;
            limit_reg      <= 32'd60;
            recalc_reg     <= 1'b0;
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            tick_reg       <= '0;
            in_use_reg     <= '0;
            local_reg      <= '0;
            coll_seq_reg   <= 32'd0;
            las_reg        <= 32'd0;
            armed_reg      <= 1'b0;
            emit_cnt_reg   <= 3'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < CONTEXTS; i++) begin
                phase_reg[i] <= PH_SYNC;
                prev_reg[i]  <= 7'd0;
                fwd_reg[i]   <= 7'd0;
                seq_reg[i]   <= 32'd0;
                seen_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid && (cfg_index == CFG_PEER_COUNT || cfg_index == CFG_OWN_ID)) begin
                recalc_reg <= 1'b1;
            end else if (recalc_clr && go) begin
                recalc_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PEER_COUNT: peer_count_reg <= cfg_data[6:0];
                    CFG_OWN_ID:     own_id_reg <= cfg_data[5:0];
                    CFG_TIMEOUT:    limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (go) begin
                state_reg    <= state_next;
                slot_reg     <= slot_next;
                tick_reg     <= tick_next;
                in_use_reg   <= in_use_next;
                local_reg    <= local_next;
                coll_seq_reg <= coll_seq_next;
                las_reg      <= las_next;
                armed_reg    <= armed_next;
                phase_reg    <= phase_next;
                prev_reg     <= prev_next;
                fwd_reg      <= fwd_next;
                seq_reg      <= seq_next;
                seen_reg     <= seen_next;
            end
            if (item_start && go) emit_cnt_reg <= 3'd0;
            else if (go && emit_ok) emit_cnt_reg <= emit_cnt_reg + 3'd1;
            if (go && emit_ok) pend_valid_reg <= 1'b1;
            else if (flush_push) pend_valid_reg <= 1'b0;
            if (push_pend || flush_push) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/ring_allgather_control.sv -----
// ---------------------------------------------------------------------------
// ring_allgather_control
// Control engine of a ring allgather over a small pool of collective contexts.
// ---------------------------------------------------------------------------
// Usage:
//   s_*   event items (local contribution, neighbour message, send done, tick).
//   m_*   result items (reject, forward, deliver, complete, timeout drop);
//         every event that gives results marks its final one with last.
//   cfg_* register writes: 0 peer_count, 1 own_peer_id, 2 timeout_limit.
// Flow: a two-entry queue sits between intake and the engine. A neighbour
//   message that passes the size check also goes through the bit-serial
//   remainder unit, and a tick scans one context per cycle while the output
//   does not stall. One item is worked on at a time.
// A write to peer_count or own_peer_id starts a remainder pass for the
//   effective ring position; no event is started until it finishes.
// Reset (aresetn low, synchronous) frees all contexts and loads the register
//   defaults. When m_ready is low, one result waits in the output register and
//   one more in a holding stage; the engine then stalls while the queue still
//   takes up to two items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_allgather_control
    import rag_pkg::*;
#(
    parameter int CONTEXTS  = 3,
    parameter int MAX_PEERS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic    q_valid;
    q_item_t q_data;
    logic    q_pop;

    assign cfg_ready = 1'b1;

    rag_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    rag_engine #(
        .CONTEXTS  (CONTEXTS),
        .MAX_PEERS (MAX_PEERS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_ring_allgather_control.sv -----
// ---------------------------------------------------------------------------
// tb_ring_allgather_control
// Self-checking bench for the ring allgather control engine: a local model
// predicts the result items of every accepted event, a monitor compares them
// in order. Directed cases first, then random rounds of ring traffic over
// several register settings, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ring_allgather_control;
    import rag_pkg::*;

    localparam int NCTX = 3;
    localparam int PEERS_MAX = 64;
    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #4 aclk = ~aclk;

    ring_allgather_control u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // engine state mirror
    logic [6:0]  peer_reg;
    logic [5:0]  own_reg;
    logic [31:0] tmo_reg;
    logic        ctx_busy [NCTX];
    logic [1:0]  ctx_phase [NCTX];
    logic        ctx_local [NCTX];
    logic [6:0]  ctx_prev [NCTX];
    logic [6:0]  ctx_fwd [NCTX];
    logic [31:0] ctx_seq [NCTX];
    logic [63:0] ctx_seen [NCTX];
    logic [31:0] coll_seq;
    logic [31:0] last_act;
    logic        cb_armed;

    in_item_t  pending_events[$];
    out_item_t expected_results[$];
    out_item_t new_results[$];
    int        n_fail = 0;
    int        n_mismatch = 0;
    int        idle_cycles = 0;
    bit        stim_done = 0;

    function automatic logic [31:0] ring_size();
        if (peer_reg == 0) return 1;
        if (peer_reg > PEERS_MAX) return PEERS_MAX;
        return {25'd0, peer_reg};
    endfunction

    function automatic logic [31:0] ring_pos();
        return {26'd0, own_reg} % ring_size();
    endfunction

    function automatic void post(logic [2:0] k, logic [2:0] r, int slot, logic [31:0] seq,
                                 logic [5:0] org, logic [5:0] hop);
        out_item_t o;
        if (new_results.size() >= 4) return;
        o.kind = k; o.reason = r; o.ctx_slot = slot[1:0]; o.out_seq = seq;
        o.fwd_origin = org; o.fwd_hop = hop; o.last = 1'b0;
        new_results.push_back(o);
    endfunction

    function automatic void release_ctx(int i, logic [31:0] now);
        ctx_busy[i] = 0; ctx_phase[i] = PH_SYNC; ctx_local[i] = 0;
        ctx_prev[i] = 0; ctx_fwd[i] = 0; ctx_seen[i] = '0;
        last_act = now;
    endfunction

    function automatic void step_phase(int i, logic [31:0] now);
        logic [31:0] p;
        bit again;
        p = ring_size();
        again = 1;
        while (again) begin
            again = 0;
            if (ctx_phase[i] == PH_SYNC) begin
                if (ctx_local[i] || ctx_prev[i] != 0) begin
                    ctx_phase[i] = PH_PROG; again = 1;
                end
            end else if (ctx_phase[i] == PH_PROG) begin
                if ({25'd0, ctx_prev[i]} + ctx_local[i] == p) begin
                    ctx_phase[i] = PH_FIN;
                    if (cb_armed) begin
                        post(KIND_DELIVER, RSN_NONE, i, ctx_seq[i], 0, 0);
                        cb_armed = 0;
                    end
                    again = 1;
                end
            end else if (ctx_phase[i] == PH_FIN) begin
                if ({25'd0, ctx_fwd[i]} + 1 == p) begin
                    coll_seq++;
                    post(KIND_COMPLETE, RSN_NONE, i, ctx_seq[i], 0, 0);
                    release_ctx(i, now);
                    again = 1;
                end
            end
        end
    endfunction

    function automatic void contribute(int i, logic [31:0] org, logic [31:0] hop,
                                       logic [31:0] now);
        last_act = now;
        if (org != (ring_pos() + 1) % ring_size())
            post(KIND_FORWARD, RSN_NONE, i, ctx_seq[i], org[5:0], hop[5:0]);
    endfunction

    function automatic void predict_event(in_item_t e);
        int found, spare;
        logic [31:0] p, seq, want, org;
        new_results.delete();
        p = ring_size();
        found = -1; spare = -1;
        case (e.mode)
            MODE_LOCAL: begin
                seq = coll_seq;
                cb_armed = 1;
                for (int i = 0; i < NCTX; i++) begin
                    if (ctx_busy[i]) begin
                        if (ctx_phase[i] == PH_FIN) seq++;
                        else if (found < 0 && !ctx_local[i]) found = i;
                    end else spare = i;
                end
                if (found < 0 && spare >= 0) begin
                    found = spare; ctx_busy[found] = 1; ctx_seq[found] = seq;
                end
                if (found < 0) post(KIND_REJECT, RSN_NOCTX, 0, coll_seq, 0, 0);
                else begin
                    contribute(found, ring_pos(), 0, e.now_time);
                    ctx_local[found] = 1;
                    step_phase(found, e.now_time);
                end
            end
            MODE_MSG: begin
                org = {24'd0, e.origin_id};
                for (int i = 0; i < NCTX; i++) begin
                    if (found < 0) begin
                        if (ctx_busy[i] && ctx_seq[i] == e.msg_seq) found = i;
                        else if (!ctx_busy[i]) spare = i;
                    end
                end
                if (found < 0 && spare >= 0) begin
                    found = spare; ctx_busy[found] = 1; ctx_seq[found] = e.msg_seq;
                end
                want = ((ring_pos() + p - org) % p) - 1;
                if (found < 0) post(KIND_REJECT, RSN_NOCTX, 0, e.msg_seq, 0, 0);
                else if (!e.size_matches)
                    post(KIND_REJECT, RSN_SIZE, found, ctx_seq[found], 0, 0);
                else if ({26'd0, e.hop_number} != want)
                    post(KIND_REJECT, RSN_HOP, found, ctx_seq[found], 0, 0);
                else if (org >= p)
                    post(KIND_REJECT, RSN_RANGE, found, ctx_seq[found], 0, 0);
                else if (ctx_seen[found][org[5:0]])
                    post(KIND_REJECT, RSN_DUP, found, ctx_seq[found], 0, 0);
                else begin
                    ctx_seen[found][org[5:0]] = 1;
                    contribute(found, org, {26'd0, e.hop_number} + 1, e.now_time);
                    ctx_prev[found]++;
                    step_phase(found, e.now_time);
                end
            end
            MODE_SENT: begin
                if (e.context_index < NCTX && ctx_busy[e.context_index]
                        && ctx_seq[e.context_index] == e.msg_seq) begin
                    ctx_fwd[e.context_index]++;
                    step_phase(e.context_index, e.now_time);
                end
            end
            default: begin
                for (int i = 0; i < NCTX; i++) begin
                    if (ctx_busy[i] && ctx_phase[i] != PH_SYNC
                            && (e.now_time - last_act) > tmo_reg) begin
                        cb_armed = 0;
                        post(KIND_TIMEOUT, RSN_NONE, i, ctx_seq[i], 0, 0);
                        release_ctx(i, e.now_time);
                    end
                end
            end
        endcase
        if (new_results.size() > 0) new_results[new_results.size() - 1].last = 1'b1;
        foreach (new_results[k]) expected_results.push_back(new_results[k]);
    endfunction

    // handshakes seen at the rising edge
    bit s_acc = 0;
    bit m_acc = 0;
    always @(posedge aclk) begin
        s_acc <= s_valid && s_ready;
        m_acc <= m_valid && m_ready;
    end

    // driver
    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_acc) begin
                predict_event(s_data);
                s_gap = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) s_gap = 0;
            end
            if (!s_valid || s_acc) begin
                if (s_gap > 0 || pending_events.size() == 0) begin
                    s_valid <= 1'b0;
                    if (s_gap > 0) s_gap--;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= pending_events.pop_front();
                end
            end
        end
    end

    // receiver stalls, drawn per result
    int m_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_acc) m_gap = $urandom_range(0, 5);
            if (m_gap > 0) begin
                m_ready <= 1'b0; m_gap--;
            end else m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                n_fail++;
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item %p", m_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data !== exp_r) begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, m_data);
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn && !stim_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (pending_events.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_PEER_COUNT) peer_reg = val[6:0];
        else if (idx == CFG_OWN_ID) own_reg = val[5:0];
        else if (idx == CFG_TIMEOUT) tmo_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t ev(logic [31:0] md, logic [31:0] seq, logic [31:0] org,
                                    logic [31:0] hop, logic [31:0] ok, logic [31:0] idx,
                                    logic [31:0] now);
        in_item_t e;
        e.mode = md[1:0]; e.msg_seq = seq; e.origin_id = org[7:0];
        e.hop_number = hop[5:0]; e.size_matches = ok[0]; e.context_index = idx[1:0];
        e.now_time = now;
        return e;
    endfunction

    // one well-formed collective with random noise; seq guessed from the model
    task automatic queue_round(logic [31:0] t0);
        logic [31:0] p, me, seq, org, now;
        p = ring_size(); me = ring_pos(); seq = coll_seq; now = t0;
        pending_events.push_back(ev(MODE_LOCAL, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, now));
        for (int k = 1; k < p && k < 6; k++) begin
            org = (me + p - k) % p;
            now += $urandom_range(0, 20);
            if ($urandom_range(0, 7) == 0)
                pending_events.push_back(ev(MODE_MSG, seq, $urandom, $urandom, $urandom,
                                            $urandom, now));
            pending_events.push_back(ev(MODE_MSG, seq, org, k - 1, 1, $urandom, now));
        end
        for (int k = 0; k < p - 1 && k < 6; k++)
            pending_events.push_back(ev(MODE_SENT, seq, $urandom, $urandom, $urandom,
                                        $urandom_range(0, 3), now));
        if ($urandom_range(0, 2) == 0)
            pending_events.push_back(ev(MODE_TICK, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom_range(0, 1) ? now + 5 : $urandom));
    endtask

    initial begin
        logic [31:0] t;
        peer_reg = 1; own_reg = 0; tmo_reg = 60;
        for (int i = 0; i < NCTX; i++) begin
            release_ctx(i, 0); ctx_seq[i] = 0;
        end
        coll_seq = 0; last_act = 0; cb_armed = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: single node ring, then a 4-node ring with each reject cause
        pending_events.push_back(ev(MODE_LOCAL, 0, 0, 0, 1, 0, 10));
        pending_events.push_back(ev(MODE_SENT, 32'hFFFF_FFFF, 8'hFF, 6'h3F, 1, 3, 0));
        pending_events.push_back(ev(MODE_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        wait_drain();
        write_reg(CFG_PEER_COUNT, 4);
        write_reg(CFG_OWN_ID, 1);
        write_reg(CFG_TIMEOUT, 100);
        pending_events.push_back(ev(MODE_MSG, 7, 0, 0, 0, 0, 20));   // size
        pending_events.push_back(ev(MODE_MSG, 7, 0, 5, 1, 0, 21));   // hop
        pending_events.push_back(ev(MODE_MSG, 7, 8'hFF, 1, 1, 0, 22)); // range
        pending_events.push_back(ev(MODE_MSG, 7, 0, 0, 1, 0, 23));   // good
        pending_events.push_back(ev(MODE_MSG, 7, 0, 0, 1, 0, 24));   // duplicate
        pending_events.push_back(ev(MODE_MSG, 8, 0, 0, 1, 0, 25));
        pending_events.push_back(ev(MODE_MSG, 9, 0, 0, 1, 0, 26));
        pending_events.push_back(ev(MODE_MSG, 10, 0, 0, 1, 0, 27));  // no context
        pending_events.push_back(ev(MODE_LOCAL, 0, 0, 0, 1, 0, 28));
        pending_events.push_back(ev(MODE_LOCAL, 0, 0, 0, 1, 0, 29));
        pending_events.push_back(ev(MODE_LOCAL, 0, 0, 0, 1, 0, 30));
        pending_events.push_back(ev(MODE_LOCAL, 0, 0, 0, 1, 0, 31)); // no context
        pending_events.push_back(ev(MODE_TICK, 0, 0, 0, 0, 0, 32'h8000_0000));
        wait_drain();

        // random rounds over register settings, extremes included
        t = 1000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_PEER_COUNT, 0); write_reg(CFG_OWN_ID, 63); end
                1: begin write_reg(CFG_PEER_COUNT, 127); write_reg(CFG_OWN_ID, 0); end
                2: begin write_reg(CFG_TIMEOUT, 0); write_reg(CFG_PEER_COUNT, 3); end
                3: begin write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF); write_reg(CFG_OWN_ID, 2); end
                4: begin write_reg(CFG_PEER_COUNT, 64); write_reg(CFG_OWN_ID, 42); end
                default: begin
                    write_reg(CFG_PEER_COUNT, $urandom_range(2, 6));
                    write_reg(CFG_OWN_ID, $urandom_range(0, 63));
                    write_reg(CFG_TIMEOUT, $urandom_range(0, 50));
                end
            endcase
            for (int r = 0; r < 3; r++) begin
                if ($urandom_range(0, 4) == 0) begin
                    pending_events.push_back(ev($urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom));
                end
                queue_round(t);
                t += $urandom_range(0, 200);
                wait_drain();
            end
        end

        stim_done = 1;
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
